@@ src/best_rational_approximation_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the rational approximation block.
// Each macro gives a labelled concurrent assertion; empty under SYNTHESIS.
// ----------------------------------------------------------------------------
`ifndef BEST_RATIONAL_APPROXIMATION_MACROS_SVH
`define BEST_RATIONAL_APPROXIMATION_MACROS_SVH
`ifndef SYNTHESIS
`define BRA_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define BRA_ASSERT_RST(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define BRA_ASSERT(label, clk, rst_n, prop)
`define BRA_ASSERT_RST(label, clk, prop)
`endif
`endif

@@ src/bra_pkg.sv @@
// ----------------------------------------------------------------------------
// Rational approximation package
// Payload types, controller states, command and status structs.
// ----------------------------------------------------------------------------
package bra_pkg;

  localparam int unsigned IntW = 32;
  localparam int unsigned FracBits = 48;
  localparam int unsigned DenW = 32;
  localparam int unsigned PrecW = 48;
  localparam logic [PrecW-1:0] PrecReset = 48'd28;
  localparam logic [DenW:0] DenLimitA = 33'h0_FFFF_FFFF;
  localparam logic [DenW:0] DenLimitB = 33'h0_7FFF_FFFF;
  localparam int unsigned MaxSteps = 64;

  typedef enum logic [1:0] {
    CAUSE_HIGH  = 2'd0,
    CAUSE_LOW   = 2'd1,
    CAUSE_LIMIT = 2'd2
  } cause_e;

  typedef enum logic [3:0] {
    ST_IDLE, ST_ERR, ST_TEST, ST_DIV, ST_MUL, ST_ADV1, ST_ADV2,
    ST_FIN1, ST_FIN2, ST_OUT
  } state_e;

  typedef struct packed {
    logic [IntW-1:0] int_part;
    logic [PrecW-1:0] frac_part;
  } in_t;

  typedef struct packed {
    logic [IntW-1:0] numerator;
    logic [DenW-1:0] denominator;
    logic            num_overflow;
    logic [1:0]      stop_cause;
  } out_t;

  typedef struct packed {
    logic load;
    logic err;
    logic div_start;
    logic mul;
    logic adv1;
    logic adv2;
    logic fin1;
    logic fin2;
    logic stop_high;
    logic stop_low;
    logic stop_limit;
  } cmd_t;

  typedef struct packed {
    logic hit_high;
    logic hit_low;
    logic div_done;
    logic limit;
  } sts_t;

endpackage

@@ src/bra_div.sv @@
// ----------------------------------------------------------------------------
// Restoring divider
// Unsigned quotient and remainder, one bit per cycle.
// ----------------------------------------------------------------------------
module bra_div #(
  parameter int unsigned W = 64
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [W-1:0] num_i,
  input  logic [W-1:0] den_i,
  output logic         done_o,
  output logic [W-1:0] quo_o,
  output logic [W-1:0] rem_o
);
  localparam int unsigned CntW = $clog2(W + 1);

  logic [W-1:0]    quo_q, quo_d, den_q, den_d;
  logic [W:0]      rem_q, rem_d, trial;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d;

  always_comb begin
    quo_d = quo_q;
    rem_d = rem_q;
    den_d = den_q;
    cnt_d = cnt_q;
    busy_d = busy_q;
    trial = {rem_q[W-1:0], quo_q[W-1]} - {1'b0, den_q};
    if (start_i) begin
      quo_d = num_i;
      den_d = den_i;
      rem_d = '0;
      cnt_d = CntW'(W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[W]) begin
        rem_d = trial;
        quo_d = {quo_q[W-2:0], 1'b1};
      end else begin
        rem_d = {rem_q[W-1:0], quo_q[W-1]};
        quo_d = {quo_q[W-2:0], 1'b0};
      end
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign done_o = busy_q && (cnt_q == CntW'(1));
  assign quo_o = quo_d;
  assign rem_o = rem_d[W-1:0];
endmodule

@@ src/bra_dp.sv @@
// ----------------------------------------------------------------------------
// Rational approximation datapath
// Bounds, scaled errors, quotient and result formation.
// ----------------------------------------------------------------------------
module bra_dp (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  bra_pkg::in_t             in_i,
  input  logic [bra_pkg::PrecW-1:0] prec_i,
  input  bra_pkg::cmd_t            cmd_i,
  output bra_pkg::sts_t            sts_o,
  output bra_pkg::out_t            res_o
);
  localparam int unsigned DW = bra_pkg::DenW + 1;

  logic [63:0] el_q, eh_q, r_q;
  logic [DW-1:0] ln_q, ld_q, hn_q, hd_q;
  logic [31:0] ip_q;
  logic [31:0] n_q;
  logic        big_q, nbig_q;
  logic [63:0] pa_q, pb_q;
  logic [31:0] rn_q, rd_q;
  logic [1:0]  cause_q;
  logic [63:0] tot_q;
  logic [63:0] quo, rem, dnum, dden, prec64;
  logic        dvdone;

  assign prec64 = 64'(prec_i);
  assign dnum = big_q ? eh_q : el_q;
  assign dden = big_q ? el_q : eh_q;

  bra_div #(.W(64)) u_div (
    .clk_i, .rst_ni, .start_i(cmd_i.div_start), .num_i(dnum), .den_i(dden),
    .done_o(dvdone), .quo_o(quo), .rem_o(rem)
  );

  // The new error of the advanced bound is the division remainder.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      el_q <= 64'(in_i.frac_part[bra_pkg::FracBits-1:0]);
      eh_q <= (64'd1 << bra_pkg::FracBits)
          - 64'(in_i.frac_part[bra_pkg::FracBits-1:0]);
      ip_q <= in_i.int_part;
      ln_q <= '0; ld_q <= DW'(1); hn_q <= DW'(1); hd_q <= DW'(1);
    end
    if (cmd_i.err) begin
      big_q <= eh_q > el_q;
    end
    if (dvdone) begin
      nbig_q <= quo >= 64'hFFFF_FFFF;
      n_q <= quo[31:0];
      r_q <= rem;
    end
    if (cmd_i.mul) begin
      pa_q <= (big_q ? 64'(ld_q) : 64'(hd_q)) * 64'({1'b0, n_q} + 33'd1);
      pb_q <= (big_q ? 64'(ln_q) : 64'(hn_q)) * 64'(n_q);
    end
    if (cmd_i.adv1) begin
      if (big_q) begin
        hn_q <= DW'(pb_q + 64'(hn_q));
        hd_q <= DW'(pa_q - 64'(ld_q) + 64'(hd_q));
        eh_q <= r_q;
        el_q <= el_q - r_q;
      end else begin
        ln_q <= DW'(pb_q + 64'(ln_q));
        ld_q <= DW'(pa_q - 64'(hd_q) + 64'(ld_q));
        el_q <= r_q;
        eh_q <= eh_q - r_q;
      end
    end
    if (cmd_i.adv2) begin
      if (big_q) begin
        ln_q <= hn_q + ln_q;
        ld_q <= hd_q + ld_q;
      end else begin
        hn_q <= ln_q + hn_q;
        hd_q <= ld_q + hd_q;
      end
    end
    if (cmd_i.stop_low) begin
      rn_q <= ln_q[31:0]; rd_q <= ld_q[31:0]; cause_q <= bra_pkg::CAUSE_LOW;
    end else if (cmd_i.stop_high) begin
      rn_q <= hn_q[31:0]; rd_q <= hd_q[31:0]; cause_q <= bra_pkg::CAUSE_HIGH;
    end else if (cmd_i.stop_limit) begin
      rn_q <= hn_q[31:0]; rd_q <= hd_q[31:0]; cause_q <= bra_pkg::CAUSE_LIMIT;
    end
    if (cmd_i.fin1) tot_q <= 64'(rd_q) * 64'(ip_q);
    if (cmd_i.fin2) tot_q <= tot_q + 64'(rn_q);
  end

  assign sts_o.hit_high = (eh_q == '0) || (eh_q < prec64);
  assign sts_o.hit_low = (el_q == '0) || (el_q < prec64);
  assign sts_o.div_done = dvdone;
  assign sts_o.limit = nbig_q || (big_q
      ? (pa_q + 64'(hd_q) >= 64'(bra_pkg::DenLimitA))
      : (pa_q + 64'(ld_q) >= 64'(bra_pkg::DenLimitB)));

  assign res_o.numerator = tot_q[31:0];
  assign res_o.denominator = rd_q;
  assign res_o.num_overflow = tot_q[63:32] != '0;
  assign res_o.stop_cause = cause_q;
endmodule

@@ src/bra_ctrl.sv @@
// ----------------------------------------------------------------------------
// Rational approximation controller
// Sequences load, error test, divide, bound update and result.
// ----------------------------------------------------------------------------
`include "best_rational_approximation_macros.svh"
module bra_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  input  bra_pkg::sts_t  sts_i,
  output bra_pkg::cmd_t  cmd_o
);
  bra_pkg::state_e state_q, state_d;
  logic [6:0] step_q, step_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bra_pkg::ST_IDLE;
      step_q <= '0;
    end else begin
      state_q <= state_d;
      step_q <= step_d;
    end
  end

  always_comb begin
    state_d = state_q;
    step_d = step_q;
    cmd_o = '0;
    in_ready_o = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      bra_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          step_d = '0;
          state_d = bra_pkg::ST_ERR;
        end
      end
      bra_pkg::ST_ERR: begin
        cmd_o.err = 1'b1;
        state_d = bra_pkg::ST_TEST;
      end
      bra_pkg::ST_TEST: begin
        if (step_q == 7'(bra_pkg::MaxSteps)) begin
          cmd_o.stop_limit = 1'b1;
          state_d = bra_pkg::ST_FIN1;
        end else if (sts_i.hit_high) begin
          cmd_o.stop_high = 1'b1;
          state_d = bra_pkg::ST_FIN1;
        end else if (sts_i.hit_low) begin
          cmd_o.stop_low = 1'b1;
          state_d = bra_pkg::ST_FIN1;
        end else begin
          cmd_o.div_start = 1'b1;
          state_d = bra_pkg::ST_DIV;
        end
      end
      bra_pkg::ST_DIV: begin
        if (sts_i.div_done) state_d = bra_pkg::ST_MUL;
      end
      bra_pkg::ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d = bra_pkg::ST_ADV1;
      end
      bra_pkg::ST_ADV1: begin
        if (sts_i.limit) begin
          cmd_o.stop_limit = 1'b1;
          state_d = bra_pkg::ST_FIN1;
        end else begin
          cmd_o.adv1 = 1'b1;
          state_d = bra_pkg::ST_ADV2;
        end
      end
      bra_pkg::ST_ADV2: begin
        cmd_o.adv2 = 1'b1;
        step_d = step_q + 7'd1;
        state_d = bra_pkg::ST_ERR;
      end
      bra_pkg::ST_FIN1: begin
        cmd_o.fin1 = 1'b1;
        state_d = bra_pkg::ST_FIN2;
      end
      bra_pkg::ST_FIN2: begin
        cmd_o.fin2 = 1'b1;
        state_d = bra_pkg::ST_OUT;
      end
      bra_pkg::ST_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) state_d = bra_pkg::ST_IDLE;
      end
      default: state_d = bra_pkg::ST_IDLE;
    endcase
  end

  `BRA_ASSERT(a_no_both, clk_i, rst_ni, !(in_ready_o && out_valid_o))
  `BRA_ASSERT(a_step_cap, clk_i, rst_ni, step_q <= 7'(bra_pkg::MaxSteps))
  `BRA_ASSERT(a_load_err, clk_i, rst_ni, cmd_o.load |=> state_q == bra_pkg::ST_ERR)
  `BRA_ASSERT(a_fin_out, clk_i, rst_ni, cmd_o.fin2 |=> out_valid_o)
endmodule

@@ src/best_rational_approximation.sv @@
// From acceptance each refinement step passes the error and test states, the divide, the
// multiply and two bound-update states; the two result states then precede a valid result.
// One item at a time: a new value is accepted only once the result has been taken.
// Reset is asynchronous, active low; precision returns to 28 and the block idles.
// ----------------------------------------------------------------------------
// Best rational approximation
// Continued-fraction bracketing of a fixed-point fraction by a sequencer
// around a shared divider and multiplier datapath.
// ----------------------------------------------------------------------------
module best_rational_approximation (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  bra_pkg::in_t               in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output bra_pkg::out_t              out_data_o,
  input  logic                       cfg_we_i,
  input  logic [bra_pkg::PrecW-1:0]  cfg_data_i
);
  logic [bra_pkg::PrecW-1:0] prec_q;
  bra_pkg::cmd_t cmd;
  bra_pkg::sts_t sts;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) prec_q <= bra_pkg::PrecReset;
    else if (cfg_we_i) prec_q <= cfg_data_i;
  end

  bra_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
    .sts_i(sts), .cmd_o(cmd)
  );

  bra_dp u_dp (
    .clk_i, .rst_ni, .in_i(in_data_i), .prec_i(prec_q), .cmd_i(cmd),
    .sts_o(sts), .res_o(out_data_o)
  );
endmodule
